// ===== rtl/tsda_pkg.sv =====
`default_nettype none

package tsda_pkg;

   // build defaults
   localparam int TSDA_RING_DEPTH  = 128;
   localparam int TSDA_SAMPLE_BITS = 10;

   // register widths are fixed
   localparam int DEC_BITS = 9;
   localparam int THR_BITS = 10;

   localparam logic [DEC_BITS-1:0] DEC_RESET = 9'd1;
   localparam logic [THR_BITS-1:0] THR_RESET = 10'd11;   // 0.05 V at 5 V / 1023

   // configuration channel
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DECIMATION_FACTOR = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEVEL_THRESHOLD   = 2'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_DIVIDE
   } tsda_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } tsda_div_status_type;

endpackage

`default_nettype wire

// ===== rtl/tsda_if.sv =====
`default_nettype none

interface tsda_req_if
   import tsda_pkg::*;
#(
   parameter int SAMPLE_BITS = TSDA_SAMPLE_BITS
) ();
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] positive_sample;
   logic [SAMPLE_BITS-1:0] negative_sample;

   modport source (output valid, output positive_sample, output negative_sample, input ready);
   modport sink   (input valid, input positive_sample, input negative_sample, output ready);
endinterface

interface tsda_rsp_if
   import tsda_pkg::*;
#(
   parameter int SAMPLE_BITS = TSDA_SAMPLE_BITS,
   parameter int RING_DEPTH  = TSDA_RING_DEPTH
) ();
   localparam int SLOT_W = $clog2(RING_DEPTH);
   localparam int FILL_W = $clog2(RING_DEPTH + 1);

   logic                    valid;
   logic                    ready;
   logic signed [SAMPLE_BITS:0] average_value;
   logic [SLOT_W-1:0]       ring_slot;
   logic [FILL_W-1:0]       fill_count;

   modport source (output valid, output average_value, output ring_slot, output fill_count,
                   input ready);
   modport sink   (input valid, input average_value, input ring_slot, input fill_count,
                   output ready);
endinterface

interface tsda_csr_if
   import tsda_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/threshold_select_decimating_averager.sv =====
`default_nettype none

// Threshold-select decimating averager. Each req beat carries a pair of raw
// converter counts; the positive channel is taken if it is at or above the
// level threshold, else the negative channel negated if it meets it, else zero.
// Selected values accumulate until the sample count reaches decimation_factor
// (a factor of 0 behaves as 1); then one rsp beat carries the mean, truncated
// toward zero (volts = counts * 5 / 1023), the display-ring slot it goes to and
// the saturating ring fill count. An item that produces no result is accepted,
// then accumulated. An item that closes a block is accepted, then its mean comes
// from a restoring divider that retires one quotient bit per cycle over the
// SUM_W-bit sum, then it is loaded into the output register once that is free.
// req is ready only in idle. The result sits in an output register, so
// the next item is taken while the rsp beat waits. Configuration writes are
// always ready; writing decimation_factor clears the accumulator, writing
// level_threshold takes effect on the next item. Unlisted indices are ignored.

module threshold_select_decimating_averager
   import tsda_pkg::*;
#(
   parameter int RING_DEPTH  = TSDA_RING_DEPTH,
   parameter int SAMPLE_BITS = TSDA_SAMPLE_BITS
) (
   input wire logic  clock,
   input wire logic  reset,
   tsda_req_if.sink  req_if,
   tsda_rsp_if.source rsp_if,
   tsda_csr_if.sink  csr_if
);

   localparam int SUM_W  = SAMPLE_BITS + DEC_BITS + 1;   // 511 full-scale samples, signed
   localparam int AVG_W  = SAMPLE_BITS + 1;
   localparam int SLOT_W = $clog2(RING_DEPTH);
   localparam int FILL_W = $clog2(RING_DEPTH + 1);
   localparam int CMP_W  = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

   tsda_state_type state_ff, state_in;

   // config
   logic [DEC_BITS-1:0]    factor_ff, factor_in;
   logic [THR_BITS-1:0]    thr_ff, thr_in;

   // accumulator and ring tracking
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [DEC_BITS-1:0]    count_ff, count_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;

   // captured sample pair
   logic [SAMPLE_BITS-1:0] pos_ff, pos_in;
   logic [SAMPLE_BITS-1:0] neg_ff, neg_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [AVG_W-1:0] avg_ff, avg_in;
   logic [SLOT_W-1:0]      ring_ff, ring_in;
   logic [FILL_W-1:0]      fill_out_ff, fill_out_in;

   logic                   req_ready;
   logic                   out_free;
   logic                   pos_hit, neg_hit;
   logic signed [SUM_W-1:0] sel;
   logic signed [SUM_W-1:0] acc_sum;
   logic [DEC_BITS-1:0]    count_next;
   logic                   emit;

   logic                   div_start;
   tsda_div_status_type    div_status;
   logic signed [AVG_W-1:0] div_quotient;

   // channel select
   assign pos_hit = CMP_W'(pos_ff) >= CMP_W'(thr_ff);
   assign neg_hit = CMP_W'(neg_ff) >= CMP_W'(thr_ff);

   always_comb begin
      priority if (pos_hit) begin
         sel = signed'(SUM_W'(pos_ff));
      end else if (neg_hit) begin
         sel = signed'(SUM_W'(0) - SUM_W'(neg_ff));
      end else begin
         sel = '0;
      end
   end

   assign acc_sum    = sum_ff + sel;
   assign count_next = count_ff + DEC_BITS'(1);
   // a wrapped count never emits; factor 0 emits every sample
   assign emit       = (count_next != '0) && (count_next >= factor_ff);

   // output register frees when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      state_in     = state_ff;
      factor_in    = factor_ff;
      thr_in       = thr_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      slot_in      = slot_ff;
      fill_in      = fill_ff;
      pos_in       = pos_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      avg_in       = avg_ff;
      ring_in      = ring_ff;
      fill_out_in  = fill_out_ff;
      div_start    = 1'b0;
      req_ready    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_if.valid) begin
               pos_in   = req_if.positive_sample;
               neg_in   = req_if.negative_sample;
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            if (emit) begin
               // divider latches the closing sum and count
               div_start = 1'b1;
               sum_in    = '0;
               count_in  = '0;
               state_in  = ST_DIVIDE;
            end else begin
               sum_in   = acc_sum;
               count_in = count_next;
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done && out_free) begin
               rsp_valid_in = 1'b1;
               avg_in       = div_quotient;
               ring_in      = slot_ff;
               slot_in      = (slot_ff == SLOT_W'(RING_DEPTH - 1)) ? '0
                                                                   : slot_ff + SLOT_W'(1);
               if (fill_ff < FILL_W'(RING_DEPTH)) begin
                  fill_in     = fill_ff + FILL_W'(1);
                  fill_out_in = fill_ff + FILL_W'(1);
               end else begin
                  fill_out_in = fill_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // config writes must arrive only while idle; the user keeps to it, not the block
      if (csr_if.valid) begin
         if (csr_if.index == CSR_DECIMATION_FACTOR) begin
            factor_in = csr_if.data[DEC_BITS-1:0];
            sum_in    = '0;
            count_in  = '0;
         end else if (csr_if.index == CSR_LEVEL_THRESHOLD) begin
            thr_in = csr_if.data[THR_BITS-1:0];
         end
      end
   end

   tsda_divider #(
      .SUM_W (SUM_W),
      .DIV_W (DEC_BITS),
      .Q_W   (AVG_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_sum),
      .divisor  (count_next),
      .status   (div_status),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         factor_ff    <= DEC_RESET;
         thr_ff       <= THR_RESET;
         sum_ff       <= '0;
         count_ff     <= '0;
         slot_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         factor_ff    <= factor_in;
         thr_ff       <= thr_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff      <= pos_in;
      neg_ff      <= neg_in;
      avg_ff      <= avg_in;
      ring_ff     <= ring_in;
      fill_out_ff <= fill_out_in;
   end

   assign req_if.ready         = req_ready;
   assign csr_if.ready         = 1'b1;
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.average_value = avg_ff;
   assign rsp_if.ring_slot     = ring_ff;
   assign rsp_if.fill_count    = fill_out_ff;

   // a new rsp beat only comes out of a finished division
   a_rsp_from_div: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff == ST_DIVIDE) && $past(div_status.done)))
      else $error("rsp beat without finished division");

   // while waiting on the divider it is running or holding a result
   a_div_engaged: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (div_status.busy || div_status.done))
      else $error("divide state with idle divider");

   // accumulator count stays below the factor between items
   a_count_below_factor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ((count_ff == '0) || (count_ff < factor_ff)))
      else $error("sample count reached factor without emit");

   // ring tracking stays in range
   a_ring_range: assert property (@(posedge clock) disable iff (reset)
      (fill_ff <= FILL_W'(RING_DEPTH)) && (slot_ff <= SLOT_W'(RING_DEPTH - 1)))
      else $error("ring slot or fill count out of range");

endmodule

`default_nettype wire

// ===== rtl/tsda_divider.sv =====
`default_nettype none

// Restoring signed/unsigned divider, one quotient bit per cycle.
// Quotient truncates toward zero; result holds until the next start.
module tsda_divider
   import tsda_pkg::*;
#(
   parameter int SUM_W = TSDA_SAMPLE_BITS + DEC_BITS + 1,
   parameter int DIV_W = DEC_BITS,
   parameter int Q_W   = TSDA_SAMPLE_BITS + 1
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic signed [SUM_W-1:0] dividend,
   input  wire logic [DIV_W-1:0]        divisor,
   output tsda_div_status_type          status,
   output logic signed [Q_W-1:0]        quotient
);

   localparam int STEP_W = $clog2(SUM_W);

   logic [SUM_W-1:0]  quot_ff, quot_in;
   logic [DIV_W:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]  dvs_ff, dvs_in;
   logic              neg_ff, neg_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DIV_W:0]    shifted;
   logic              fits;
   logic [Q_W-1:0]    mag;

   assign shifted = {rem_ff[DIV_W-1:0], quot_ff[SUM_W-1]};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quot_in = dividend[SUM_W-1] ? (SUM_W'(0) - dividend) : dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         neg_in  = dividend[SUM_W-1];
         step_in = STEP_W'(SUM_W - 1);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in  = fits ? (shifted - {1'b0, dvs_ff}) : shifted;
         quot_in = {quot_ff[SUM_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
      step_ff <= step_in;
   end

   // magnitude never exceeds one full-scale sample
   assign mag         = quot_ff[Q_W-1:0];
   assign quotient    = neg_ff ? signed'(Q_W'(0) - mag) : signed'(mag);
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

// ===== tb/tsda_mean_checker.sv =====
`timescale 1ns / 1ps

module tsda_mean_checker
   import tsda_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   tsda_req_if       req_mon,
   tsda_rsp_if       rsp_mon,
   tsda_csr_if       csr_mon,
   output int        mismatch_count,
   output int        means_pending,
   output int        means_seen
);

   localparam int SUM_W  = TSDA_SAMPLE_BITS + DEC_BITS + 1;
   localparam int SLOT_W = $clog2(TSDA_RING_DEPTH);
   localparam int FILL_W = $clog2(TSDA_RING_DEPTH + 1);

   typedef struct packed {
      logic signed [TSDA_SAMPLE_BITS:0] average;
      logic [SLOT_W-1:0]                slot;
      logic [FILL_W-1:0]                fill;
   } mean_beat_type;

   logic [DEC_BITS-1:0]     factor;
   logic [THR_BITS-1:0]     threshold;
   logic signed [SUM_W-1:0] acc_sum;
   logic [DEC_BITS-1:0]     acc_count;
   logic [SLOT_W-1:0]       next_slot;
   logic [FILL_W-1:0]       filled;
   mean_beat_type           expected_means[$];
   mean_beat_type           got_beat;
   int                      errors = 0;
   int                      seen = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   task automatic accumulate_pair(input logic [TSDA_SAMPLE_BITS-1:0] pos,
                                  input logic [TSDA_SAMPLE_BITS-1:0] neg);
      logic signed [TSDA_SAMPLE_BITS:0] picked;
      mean_beat_type                    beat;
      if (pos >= threshold) begin
         picked = $signed({1'b0, pos});
      end else if (neg >= threshold) begin
         picked = -$signed({1'b0, neg});
      end else begin
         picked = '0;
      end
      acc_sum   = acc_sum + picked;
      acc_count = acc_count + 1'b1;
      // factor 0 closes on every pair
      if (acc_count != '0 && acc_count >= factor) begin
         beat.average = int'(acc_sum) / int'(acc_count);   // truncates toward zero
         beat.slot    = next_slot;
         next_slot    = (next_slot == SLOT_W'(TSDA_RING_DEPTH - 1)) ? '0 : next_slot + 1'b1;
         if (filled < FILL_W'(TSDA_RING_DEPTH)) begin
            filled = filled + 1'b1;
         end
         beat.fill = filled;
         expected_means.push_back(beat);
         acc_sum   = '0;
         acc_count = '0;
      end
   endtask

   task automatic check_mean(input mean_beat_type got);
      mean_beat_type want;
      if (expected_means.size() == 0) begin
         report_mismatch("unexpected beat, average_value", got.average, 0);
         return;
      end
      want = expected_means.pop_front();
      if (got.average !== want.average) begin
         report_mismatch("average_value", got.average, want.average);
      end
      if (got.slot !== want.slot) begin
         report_mismatch("ring_slot", got.slot, want.slot);
      end
      if (got.fill !== want.fill) begin
         report_mismatch("fill_count", got.fill, want.fill);
      end
   endtask

   task automatic apply_write(input logic [CSR_INDEX_BITS-1:0] index,
                              input logic [CSR_DATA_BITS-1:0]  data);
      case (index)
         CSR_DECIMATION_FACTOR: begin
            factor    = data[DEC_BITS-1:0];
            acc_sum   = '0;
            acc_count = '0;
         end
         CSR_LEVEL_THRESHOLD: begin
            threshold = data[THR_BITS-1:0];
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         factor    = DEC_RESET;
         threshold = THR_RESET;
         acc_sum   = '0;
         acc_count = '0;
         next_slot = '0;
         filled    = '0;
         expected_means.delete();
      end else begin
         // older expectation is matched before this edge's new one is queued
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen++;
            got_beat.average = rsp_mon.average_value;
            got_beat.slot    = rsp_mon.ring_slot;
            got_beat.fill    = rsp_mon.fill_count;
            check_mean(got_beat);
         end
         if (req_mon.valid && req_mon.ready) begin
            accumulate_pair(req_mon.positive_sample, req_mon.negative_sample);
         end
         if (csr_mon.valid && csr_mon.ready) begin
            apply_write(csr_mon.index, csr_mon.data);
         end
      end
      mismatch_count <= errors;
      means_pending  <= expected_means.size();
      means_seen     <= seen;
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import tsda_pkg::*;

   localparam int SAMPLE_W        = TSDA_SAMPLE_BITS;
   localparam int RUN_LIMIT       = 1_000_000;
   localparam int SETTLE_CYCLES   = 30;    // lets a closing item's 20-bit divide finish
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int RANDOM_ITEMS    = 800;
   localparam int RANDOM_MEANS    = 60;

   // indices with no register behind them
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_3 = 2'd3;

   localparam logic [SAMPLE_W-1:0] FULL_SCALE = '1;

   logic clock;
   logic reset;
   int   cycle_count = 0;
   int   items_sent  = 0;
   int   level       = THR_RESET;   // threshold the DUT currently holds
   int   mismatch_count;
   int   means_pending;
   int   means_seen;
   bit   steady       = 1'b0;       // both sides stream, no idle cycles
   bit   rsp_hold_arm = 1'b0;       // ask the receiver for one long hold-off

   tsda_req_if req_if ();
   tsda_rsp_if rsp_if ();
   tsda_csr_if csr_if ();

   threshold_select_decimating_averager i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   tsda_mean_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .csr_mon        (csr_if),
      .mismatch_count (mismatch_count),
      .means_pending  (means_pending),
      .means_seen     (means_seen)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("threshold_select_decimating_averager test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // random pacing
   // ---------------------------------------------------------------------

   // sender gap after a beat: mostly none, some short, a few long
   function automatic int idle_gap();
      int roll;
      roll = $urandom_range(0, 9);
      if (steady || roll < 6) return 0;
      if (roll < 9) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   function automatic int stall_length();
      if ($urandom_range(0, 4) != 0) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   // receiver: runs of ready broken by stalls; one long hold-off on request
   initial begin
      forever begin
         if (rsp_hold_arm) begin
            // rsp register fills, the divider finishes behind it and req stalls
            rsp_if.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_hold_arm = 1'b0;
         end else if (steady) begin
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
            rsp_if.ready <= 1'b0;
            repeat (stall_length()) @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------------
   // channel drivers
   // ---------------------------------------------------------------------

   // valid stays high into the next beat when there is no gap
   task automatic send_pair(input logic [SAMPLE_W-1:0] pos, input logic [SAMPLE_W-1:0] neg);
      int gap;
      req_if.valid           <= 1'b1;
      req_if.positive_sample <= pos;
      req_if.negative_sample <= neg;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_sent++;
      gap = idle_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0]  data);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // stop offering, wait for every mean, then let a trailing divide finish
   task automatic quiesce();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (means_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register value in the low bits, junk above so the masking gets exercised
   function automatic logic [CSR_DATA_BITS-1:0] padded(input int value, input int bits);
      logic [CSR_DATA_BITS-1:0] word;
      word = CSR_DATA_BITS'($urandom);
      word = (word << bits) | CSR_DATA_BITS'(value);
      return word;
   endfunction

   // ---------------------------------------------------------------------
   // random content, shaped around the current threshold
   // ---------------------------------------------------------------------

   function automatic logic [SAMPLE_W-1:0] near_level(input int lvl);
      int v;
      v = lvl + $urandom_range(0, 2) - 1;
      if (v < 0) v = 0;
      if (v > int'(FULL_SCALE)) v = int'(FULL_SCALE);
      return SAMPLE_W'(v);
   endfunction

   function automatic logic [SAMPLE_W-1:0] under_level(input int lvl);
      if (lvl == 0) return '0;
      return SAMPLE_W'($urandom_range(0, lvl - 1));
   endfunction

   task automatic send_random_pair();
      logic [SAMPLE_W-1:0] pos;
      logic [SAMPLE_W-1:0] neg;
      int                  roll;
      pos  = SAMPLE_W'($urandom);
      neg  = SAMPLE_W'($urandom);
      roll = $urandom_range(0, 9);
      case (roll)
         0, 1, 2: begin
            pos = near_level(level);            // positive side on the edge
         end
         3, 4: begin
            pos = under_level(level);           // negative side decides
            neg = near_level(level);
         end
         5: begin
            pos = under_level(level);           // neither active: zero
            neg = under_level(level);
         end
         6: begin
            pos = $urandom_range(0, 1) ? FULL_SCALE : '0;
            neg = $urandom_range(0, 1) ? FULL_SCALE : '0;
         end
         default: begin
         end
      endcase
      send_pair(pos, neg);
   endtask

   // one setting, then a burst of pairs, then drain
   task automatic random_phase();
      int factor;
      int roll;
      int count;
      bit write_factor;
      bit write_level;
      bit level_first;
      roll = $urandom_range(0, 19);
      if (roll < 10)      factor = $urandom_range(1, 4);
      else if (roll < 14) factor = $urandom_range(5, 16);
      else if (roll == 14) factor = 0;
      else if (roll < 18) factor = $urandom_range(17, 60);
      else                factor = $urandom_range(61, 300);
      write_factor = ($urandom_range(0, 3) != 0);
      write_level  = ($urandom_range(0, 3) != 0) || !write_factor;
      level_first  = $urandom_range(0, 1);
      if (write_level) begin
         roll = $urandom_range(0, 9);
         if (roll == 0)     level = 0;
         else if (roll == 1) level = int'(FULL_SCALE);
         else if (roll < 6) level = $urandom_range(1, 40);
         else               level = $urandom_range(0, int'(FULL_SCALE));
      end
      if ($urandom_range(0, 3) == 0) begin
         write_reg($urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3, CSR_DATA_BITS'($urandom));
      end
      if (write_level && level_first) write_reg(CSR_LEVEL_THRESHOLD, padded(level, THR_BITS));
      if (write_factor) write_reg(CSR_DECIMATION_FACTOR, padded(factor, DEC_BITS));
      if (write_level && !level_first) write_reg(CSR_LEVEL_THRESHOLD, padded(level, THR_BITS));
      steady = ($urandom_range(0, 4) == 0);
      count  = $urandom_range(20, 80) + ((factor > 40) ? factor : 0);
      repeat (count) send_random_pair();
      quiesce();
      steady = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      int base_items;
      int base_means;

      reset                  <= 1'b1;
      req_if.valid           <= 1'b0;
      req_if.positive_sample <= '0;
      req_if.negative_sample <= '0;
      csr_if.valid           <= 1'b0;
      csr_if.index           <= CSR_DECIMATION_FACTOR;
      csr_if.data            <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed: reset settings, factor 1 and threshold 11 ---
      send_pair(0, 0);                   // nothing active
      send_pair(FULL_SCALE, 0);          // top of range
      send_pair(0, FULL_SCALE);          // bottom of range, negated
      send_pair(10, 11);                 // positive one short, negative exactly on
      send_pair(11, FULL_SCALE);         // positive exactly on wins over negative
      send_pair(10, 10);                 // both just under
      send_pair(FULL_SCALE, FULL_SCALE);
      quiesce();

      // zero threshold: positive side always taken, even at 0
      write_reg(CSR_LEVEL_THRESHOLD, 16'd0);
      send_pair(0, FULL_SCALE);
      quiesce();

      // threshold at the top, data masked down to 10 bits
      write_reg(CSR_LEVEL_THRESHOLD, 16'hFFFF);
      send_pair(1022, FULL_SCALE);
      send_pair(1022, 1022);
      quiesce();

      // factor data that masks to zero: every pair closes
      write_reg(CSR_LEVEL_THRESHOLD, 16'd11);
      write_reg(CSR_DECIMATION_FACTOR, 16'hFE00);
      send_pair(500, 0);
      send_pair(0, 700);
      quiesce();

      // factor 3 with junk above; negative mean truncates toward zero
      write_reg(CSR_DECIMATION_FACTOR, 16'hFE03);
      send_pair(0, 20);
      send_pair(0, 20);
      quiesce();
      // spare indices must not touch the partial sum
      write_reg(CSR_SPARE_3, 16'hFFFF);
      write_reg(CSR_SPARE_2, 16'h0001);
      send_pair(0, 21);
      send_pair(25, 0);
      quiesce();

      // threshold change mid-block keeps the accumulator
      write_reg(CSR_LEVEL_THRESHOLD, 16'd0);
      send_pair(3, 900);
      send_pair(0, 0);
      quiesce();

      // factor write mid-block discards the partial sum
      write_reg(CSR_DECIMATION_FACTOR, 16'd4);
      send_pair(100, 0);
      send_pair(100, 0);
      quiesce();
      write_reg(CSR_DECIMATION_FACTOR, 16'd2);
      write_reg(CSR_LEVEL_THRESHOLD, 16'd11);
      level = 11;
      send_pair(0, 15);
      send_pair(0, 16);
      quiesce();

      // --- widest factor (masks to 511), full-scale positive sum ---
      write_reg(CSR_DECIMATION_FACTOR, 16'hFFFF);
      repeat (511) send_pair(FULL_SCALE, SAMPLE_W'($urandom));
      quiesce();

      // --- factor 300, full-scale negative sum ---
      write_reg(CSR_DECIMATION_FACTOR, 16'd300);
      write_reg(CSR_LEVEL_THRESHOLD, padded(int'(FULL_SCALE), THR_BITS));
      level = int'(FULL_SCALE);
      repeat (300) send_pair(SAMPLE_W'($urandom_range(0, 1022)), FULL_SCALE);
      quiesce();

      // --- back-pressure: long rsp hold while req keeps streaming ---
      write_reg(CSR_DECIMATION_FACTOR, 16'd1);
      write_reg(CSR_LEVEL_THRESHOLD, 16'd11);
      level        = 11;
      steady       = 1'b1;
      rsp_hold_arm = 1'b1;
      repeat (40) send_random_pair();
      quiesce();                         // sender waits out every mean
      steady = 1'b0;

      // --- random settings and content ---
      base_items = items_sent;
      base_means = means_seen;
      while (items_sent - base_items < RANDOM_ITEMS || means_seen - base_means < RANDOM_MEANS) begin
         random_phase();
      end

      quiesce();
      if (mismatch_count == 0) begin
         $display("threshold_select_decimating_averager test passed");
      end else begin
         $display("threshold_select_decimating_averager test failed");
      end
      $finish;
   end

endmodule
